// File: design/bars_pkg.sv
// ----------------------------------------------------------------------------
// bars_pkg
// Shared constants, types and the colour palette of the raster scan block.
// ----------------------------------------------------------------------------
package bars_pkg;

  // Video store geometry: bytes, and rows of one pixel byte plus one attribute
  localparam int StoreDepth = 16384;
  localparam int StoreRows  = (StoreDepth + 1) / 2;
  localparam int RowW       = $clog2(StoreRows);

  // Field widths of the request and result channels
  localparam int AddrW   = 14;
  localparam int ByteW   = 8;
  localparam int ColourW = 4;

  // Frame geometry
  localparam int FrameRows   = 216;
  localparam int FrameCells  = 42;
  localparam int EdgeRows    = 8;
  localparam int ActiveCells = 40;
  localparam int ScanRowW    = 8;
  localparam int ScanCellW   = 6;
  localparam int ScanBitW    = 3;
  localparam int ScanAddrW   = 13;

  // Request command codes
  typedef enum logic {
    CmdWrite = 1'b0,
    CmdEmit  = 1'b1
  } cmd_e;

  // Access to the video store: one write or one row read per cycle
  typedef struct packed {
    logic            we;
    logic            re;
    logic            odd;
    logic [RowW-1:0] row;
    logic [ByteW-1:0] wdata;
  } store_req_t;

  // Fixed 16-entry palette, 24-bit RGB
  function automatic logic [23:0] palette_rgb(input logic [ColourW-1:0] idx);
    logic [23:0] rgb;
    case (idx)
      4'd0:    rgb = 24'h000000;
      4'd1:    rgb = 24'hff0000;
      4'd2:    rgb = 24'h00ff00;
      4'd3:    rgb = 24'hffff00;
      4'd4:    rgb = 24'h0000ff;
      4'd5:    rgb = 24'hff00ff;
      4'd6:    rgb = 24'h00ffff;
      4'd7:    rgb = 24'hffffff;
      4'd8:    rgb = 24'hb0b0b0;
      4'd9:    rgb = 24'hffb0b0;
      4'd10:   rgb = 24'hb0ffb0;
      4'd11:   rgb = 24'hffffb0;
      4'd12:   rgb = 24'hb0b0ff;
      4'd13:   rgb = 24'hffb0ff;
      4'd14:   rgb = 24'hb0ffff;
      default: rgb = 24'hffb000;
    endcase
    return rgb;
  endfunction

endpackage

// File: design/bars_if.sv
// ----------------------------------------------------------------------------
// bars_if
// Request and result channels of the raster scan block (valid/ready).
// ----------------------------------------------------------------------------
interface bars_req_if;
  import bars_pkg::*;

  logic             valid;
  logic             ready;
  logic             command;
  logic [AddrW-1:0] address;
  logic [ByteW-1:0] data;

  modport source (output valid, command, address, data, input ready);
  modport sink   (input valid, command, address, data, output ready);
endinterface

interface bars_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       line_end;
  logic       frame_end;

  modport source (output valid, red, green, blue, line_end, frame_end, input ready);
  modport sink   (input valid, red, green, blue, line_end, frame_end, output ready);
endinterface

// File: design/bars_store.sv
// ----------------------------------------------------------------------------
// bars_store
// Video store: pixel and attribute byte memories sharing one row address,
// with a clearing pass after reset.
// ----------------------------------------------------------------------------
module bars_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bars_pkg::store_req_t req_i,
  output logic [7:0]          pix_o,
  output logic [7:0]          attr_o,
  output logic                busy_o
);
  import bars_pkg::*;

  logic [ByteW-1:0] pix_mem  [StoreRows];
  logic [ByteW-1:0] attr_mem [StoreRows];
  logic [ByteW-1:0] pix_q;
  logic [ByteW-1:0] attr_q;
  logic             busy_q;
  logic [RowW-1:0]  clr_q;

  // Sweep every row once after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      clr_q  <= '0;
    end else if (busy_q) begin
      if (clr_q == RowW'(StoreRows - 1)) begin
        busy_q <= 1'b0;
      end
      clr_q <= clr_q + 1'b1;
    end
  end

  // Write port: clearing sweep, else a byte write to one half of a row
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      pix_mem[clr_q]  <= '0;
      attr_mem[clr_q] <= '0;
    end else if (req_i.we) begin
      if (req_i.odd) begin
        attr_mem[req_i.row] <= req_i.wdata;
      end else begin
        pix_mem[req_i.row] <= req_i.wdata;
      end
    end
  end

  // Read port: both bytes of a row, registered
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      pix_q  <= pix_mem[req_i.row];
      attr_q <= attr_mem[req_i.row];
    end
  end

  assign pix_o  = pix_q;
  assign attr_o = attr_q;
  assign busy_o = busy_q;

endmodule

// File: design/bitmap_attribute_raster_scan.sv
// ----------------------------------------------------------------------------
// bitmap_attribute_raster_scan
// Raster scan generator for a 336x216 bitmap-with-attributes frame.
// ----------------------------------------------------------------------------
// Requests arrive on req_i. A write request (command 0) stores one byte in
// the 16K video store: even addresses hold pixel bytes, odd ones attribute
// bytes; addresses at or beyond the store depth are dropped. An emit request
// (command 1) produces one pixel on rsp_o in raster order, with line_end and
// frame_end flags. The user must set the border palette index through
// cfg_we_i and cfg_wdata_i only while the block is idle; the block itself
// does not enforce this.
// Pipeline: read stage (store row read), then output register to rsp_o.
// Throughput: one request per cycle while req_i.ready is high, writes and
// emits mixed freely; the single store port does either one write or one
// row read per cycle.
// Reset: the scan position and border index return to zero and the store
// is cleared one row per cycle while req_i.ready stays low.
// Stall: the output register holds a pixel until it is taken; one more emit
// waits behind it in the read stage, after which req_i.ready drops.
// ----------------------------------------------------------------------------
module bitmap_attribute_raster_scan (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  bars_req_if.sink                       req_i,
  bars_rsp_if.source                     rsp_o,
  input  logic                           cfg_we_i,
  input  logic [bars_pkg::ColourW-1:0]   cfg_wdata_i
);
  import bars_pkg::*;

  logic [ColourW-1:0]   border_q;
  logic [ScanRowW-1:0]  row_q, row_d;
  logic [ScanCellW-1:0] cell_q, cell_d;
  logic [ScanBitW-1:0]  bit_q, bit_d;

  logic                 req_acc;
  logic                 emit_acc;
  logic                 wr_ok;
  logic                 active;
  logic                 last_line;
  logic                 last_frame;
  logic [ScanRowW-1:0]  row_off;
  logic [ScanAddrW-1:0] scan_addr;

  store_req_t           store_req;
  logic [ByteW-1:0]     pix;
  logic [ByteW-1:0]     attr;
  logic                 store_busy;

  logic                 s1_valid_q;
  logic                 s1_border_q;
  logic [ScanBitW-1:0]  s1_bit_q;
  logic                 s1_line_q;
  logic                 s1_frame_q;
  logic                 s1_adv;
  logic [ColourW-1:0]   colour_idx;
  logic [23:0]          rgb;

  logic                 out_valid_q;
  logic [23:0]          out_rgb_q;
  logic                 out_line_q;
  logic                 out_frame_q;

  // Handshake: read stage free, or moving on this cycle
  assign s1_adv      = !out_valid_q || rsp_o.ready;
  assign req_i.ready = !store_busy && (!s1_valid_q || s1_adv);
  assign req_acc     = req_i.valid && req_i.ready;
  assign emit_acc    = req_acc && (req_i.command == CmdEmit);
  assign wr_ok       = 32'(req_i.address) < StoreDepth;

  // Border register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      border_q <= '0;
    end else if (cfg_we_i) begin
      border_q <= cfg_wdata_i;
    end
  end

  // Scan position decode and store row of the current cell
  always_comb begin
    active = (row_q >= ScanRowW'(EdgeRows)) && (row_q < ScanRowW'(FrameRows - EdgeRows))
          && (cell_q >= ScanCellW'(1)) && (cell_q < ScanCellW'(FrameCells - 1));
    last_line  = (cell_q == ScanCellW'(FrameCells - 1)) && (bit_q == '1);
    last_frame = last_line && (row_q == ScanRowW'(FrameRows - 1));
    row_off    = row_q - ScanRowW'(EdgeRows);
    scan_addr  = ScanAddrW'(row_off) * ScanAddrW'(ActiveCells)
               + ScanAddrW'(cell_q - ScanCellW'(1));
  end

  // Advance the raster position
  always_comb begin
    row_d  = row_q;
    cell_d = cell_q;
    bit_d  = bit_q + 1'b1;
    if (bit_q == '1) begin
      if (cell_q == ScanCellW'(FrameCells - 1)) begin
        cell_d = '0;
        row_d  = (row_q == ScanRowW'(FrameRows - 1)) ? '0 : row_q + 1'b1;
      end else begin
        cell_d = cell_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      cell_q <= '0;
      bit_q  <= '0;
    end else if (emit_acc) begin
      row_q  <= row_d;
      cell_q <= cell_d;
      bit_q  <= bit_d;
    end
  end

  // Store access: write request, or row read for an active emit
  always_comb begin
    store_req.we    = req_acc && (req_i.command == CmdWrite) && wr_ok;
    store_req.re    = emit_acc && active;
    store_req.odd   = req_i.address[0];
    store_req.wdata = req_i.data;
    if (req_i.command == CmdWrite) begin
      store_req.row = RowW'(req_i.address[AddrW-1:1]);
    end else begin
      store_req.row = RowW'(scan_addr);
    end
  end

  bars_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (store_req),
    .pix_o  (pix),
    .attr_o (attr),
    .busy_o (store_busy)
  );

  // Read stage: hold the emit's context while the store answers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (emit_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_acc) begin
      s1_border_q <= !active;
      s1_bit_q    <= bit_q;
      s1_line_q   <= last_line;
      s1_frame_q  <= last_frame;
    end
  end

  // Pick the palette entry: border cells take the border index, else a set pixel bit takes the upper attribute nibble
  always_comb begin
    if (s1_border_q) begin
      colour_idx = border_q;
    end else if (pix[ScanBitW'(7) - s1_bit_q]) begin
      colour_idx = attr[7:4];
    end else begin
      colour_idx = attr[3:0];
    end
    rgb = palette_rgb(colour_idx);
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_rgb_q   <= rgb;
      out_line_q  <= s1_line_q;
      out_frame_q <= s1_frame_q;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.red       = out_rgb_q[23:16];
  assign rsp_o.green     = out_rgb_q[15:8];
  assign rsp_o.blue      = out_rgb_q[7:0];
  assign rsp_o.line_end  = out_line_q;
  assign rsp_o.frame_end = out_frame_q;

  // Checks
  a_no_req_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_busy |-> !req_i.ready)
    else $error("request taken during store clearing");

  a_emit_enters_read_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_acc |=> s1_valid_q)
    else $error("emit request lost before read stage");

  a_frame_end_wraps_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_frame_q) |-> (row_q == '0 && cell_q == '0 && bit_q == '0))
    else $error("scan position did not wrap after frame end");

  a_frame_end_is_line_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_frame_q) |-> out_line_q)
    else $error("frame end without line end");

endmodule

// File: tb/sv/bitmap_attribute_raster_scan_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap_attribute_raster_scan_test
// Self-checking bench for the bitmap-with-attributes raster scan block.
// ----------------------------------------------------------------------------
// A local model keeps its own copy of the video store, the scan position and
// the border index, and predicts every pixel that an emit request produces.
// Directed requests cover reset state, border extremes and store end points.
// The scan is then walked into the active area, where random cell writes
// just ahead of the scan position are mixed with pixel runs and stray writes.
// A long output stall fills the block, and a final sweep runs through the
// bottom border to the frame end and on into the next frame.
// ----------------------------------------------------------------------------
module bitmap_attribute_raster_scan_test;
  import bars_pkg::*;

  localparam int RandomItems  = 1950;
  localparam int GapMax       = 4;
  localparam int StallMax     = 3;
  localparam int HoldCycles   = 300;
  localparam int SettleCycles = 4;
  localparam int DrainLimit   = 4000;

  // Fixed palette, entry 15 in the top 24 bits down to entry 0
  localparam logic [16*24-1:0] PaletteRgb = {
    24'hffb000, 24'hb0ffff, 24'hffb0ff, 24'hb0b0ff,
    24'hffffb0, 24'hb0ffb0, 24'hffb0b0, 24'hb0b0b0,
    24'hffffff, 24'h00ffff, 24'hff00ff, 24'h0000ff,
    24'hffff00, 24'h00ff00, 24'hff0000, 24'h000000
  };

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       line_end;
    logic       frame_end;
  } pixel_t;

  typedef enum int {RxAlways, RxMostly, RxHalf, RxPeriodic} rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [ColourW-1:0] cfg_wdata_i;

  bars_req_if req_if ();
  bars_rsp_if rsp_if ();

  bitmap_attribute_raster_scan u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Local copy of the block state
  logic [ByteW-1:0]   video_copy [StoreDepth];
  logic [ColourW-1:0] border_idx = '0;
  int scan_row = 0;
  int scan_cell = 0;
  int scan_bit = 0;
  pixel_t expected_pixels [$];

  int error_count = 0;
  int burst_left = 0;

  // Output stall control
  int hold_asks = 0;
  int hold_taken = 0;
  int hold_left = 0;
  rx_mode_e rx_mode = RxAlways;
  int rx_mode_left = 0;
  int rx_period = 2;
  int rx_phase = 0;
  int stall_run = 0;
  bit rx_want;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Give up well beyond the slowest legal run
  initial begin
    #30_000_000;
    $display("bitmap_attribute_raster_scan_test failed");
    $finish;
  end

  function automatic logic [23:0] colour_of(input logic [ColourW-1:0] idx);
    return PaletteRgb[idx*24 +: 24];
  endfunction

  // Byte address of the pixel byte of a frame cell, or -1 for border cells
  function automatic int cell_base(input int row, input int cell_idx);
    if (row < EdgeRows || row >= FrameRows - EdgeRows || cell_idx < 1 ||
        cell_idx >= FrameCells - 1)
      return -1;
    return 2 * (ActiveCells * (row - EdgeRows) + cell_idx - 1);
  endfunction

  // Pixel byte address of the cell k cells ahead of the scan position
  function automatic int ahead_base(input int k);
    int row;
    int cell_idx;
    row = scan_row;
    cell_idx = scan_cell + k;
    while (cell_idx >= FrameCells) begin
      cell_idx -= FrameCells;
      row = (row + 1) % FrameRows;
    end
    return cell_base(row, cell_idx);
  endfunction

  // Colour the current scan position, then advance it
  function automatic pixel_t scan_pixel();
    logic [23:0]      rgb;
    logic [ByteW-1:0] pix;
    logic [ByteW-1:0] attr;
    int               base;
    pixel_t           px;
    base = cell_base(scan_row, scan_cell);
    if (base < 0) begin
      rgb = colour_of(border_idx);
    end else begin
      pix = (base < StoreDepth) ? video_copy[base] : '0;
      attr = (base + 1 < StoreDepth) ? video_copy[base + 1] : '0;
      rgb = pix[7 - scan_bit] ? colour_of(attr[7:4]) : colour_of(attr[3:0]);
    end
    px.red = rgb[23:16];
    px.green = rgb[15:8];
    px.blue = rgb[7:0];
    px.line_end = (scan_cell == FrameCells - 1) && (scan_bit == 7);
    px.frame_end = px.line_end && (scan_row == FrameRows - 1);
    if (scan_bit < 7) begin
      scan_bit++;
    end else begin
      scan_bit = 0;
      if (scan_cell < FrameCells - 1) begin
        scan_cell++;
      end else begin
        scan_cell = 0;
        scan_row = (scan_row < FrameRows - 1) ? scan_row + 1 : 0;
      end
    end
    return px;
  endfunction

  // Offer one request, in bursts with random gaps, and predict on acceptance
  task automatic send_request(input cmd_e cmd, input logic [AddrW-1:0] addr,
                              input logic [ByteW-1:0] data);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      if ($urandom_range(0, 3) != 0)
        gap = $urandom_range(1, GapMax);
    end
    burst_left--;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.command <= cmd;
    req_if.address <= addr;
    req_if.data <= data;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    if (cmd == CmdWrite) begin
      if (addr < StoreDepth)
        video_copy[addr] = data;
    end else begin
      expected_pixels.push_back(scan_pixel());
    end
    @(negedge clk_i);
  endtask

  // Emit requests carry random address and data, which must be ignored
  task automatic emit_pixels(input int n);
    repeat (n) send_request(CmdEmit, AddrW'($urandom_range(0, StoreDepth - 1)),
                            ByteW'($urandom_range(0, 255)));
  endtask

  // Write both bytes of a cell with random content, in random order
  task automatic write_cell(input int base);
    if ($urandom_range(0, 1)) begin
      send_request(CmdWrite, AddrW'(base), ByteW'($urandom_range(0, 255)));
      send_request(CmdWrite, AddrW'(base + 1), ByteW'($urandom_range(0, 255)));
    end else begin
      send_request(CmdWrite, AddrW'(base + 1), ByteW'($urandom_range(0, 255)));
      send_request(CmdWrite, AddrW'(base), ByteW'($urandom_range(0, 255)));
    end
  endtask

  // Drop valid and hold until every pixel is back and the pipeline is empty
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic set_border(input logic [ColourW-1:0] idx);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= idx;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    border_idx = idx;
  endtask

  // Emit until the scan sits at the start of target_row, writing ahead now and then
  task automatic sweep_to(input int target_row);
    int base;
    do begin
      if (scan_bit == 0 && $urandom_range(0, 5) == 0) begin
        base = ahead_base(1);
        if (base >= 0)
          write_cell(base);
      end
      emit_pixels(1);
    end while (!(scan_row == target_row && scan_cell == 0 && scan_bit == 0));
  endtask

  // Border colour straight after reset, then the top palette entry
  task automatic test_reset_border();
    emit_pixels(8);
    set_border(4'd15);
    emit_pixels(8);
  endtask

  // Store end points: first and last active cells, and the unused top bytes
  task automatic test_store_extremes();
    send_request(CmdWrite, 14'd0, 8'ha5);
    send_request(CmdWrite, 14'd1, 8'hf0);
    send_request(CmdWrite, 14'd15998, 8'h0f);
    send_request(CmdWrite, 14'd15999, 8'h7e);
    send_request(CmdWrite, 14'd16383, 8'hff);
    send_request(CmdWrite, 14'd16382, 8'h00);
  endtask

  // Walk the top border rows with a border change half way down
  task automatic test_top_border();
    sweep_to(EdgeRows / 2);
    set_border(ColourW'($urandom_range(1, 14)));
    sweep_to(EdgeRows);
  endtask

  // Mostly cell writes just ahead of the scan followed by pixel runs
  task automatic test_active_random();
    int items;
    int pick;
    int k;
    int base;
    int run;
    items = 0;
    while (items < RandomItems) begin
      if ($urandom_range(0, 149) == 0)
        set_border(ColourW'($urandom_range(0, 15)));
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        k = $urandom_range(0, 3);
        base = ahead_base(k);
        if (base >= 0) begin
          write_cell(base);
          items += 2;
          if ($urandom_range(0, 7) == 0) begin
            send_request(CmdWrite, AddrW'(base + $urandom_range(0, 1)),
                         ByteW'($urandom_range(0, 255)));
            items++;
          end
        end
        run = $urandom_range(4, 8 * k + 16);
        emit_pixels(run);
        items += run;
      end else if (pick < 8) begin
        send_request(CmdWrite, AddrW'($urandom_range(0, StoreDepth - 1)),
                     ByteW'($urandom_range(0, 255)));
        items++;
      end else begin
        run = $urandom_range(1, 3);
        emit_pixels(run);
        items += run;
      end
    end
  endtask

  // Hold the output off while requests keep coming, then drain completely
  task automatic test_backpressure();
    hold_asks++;
    repeat (40) begin
      if ($urandom_range(0, 3) == 0)
        send_request(CmdWrite, AddrW'($urandom_range(0, StoreDepth - 1)),
                     ByteW'($urandom_range(0, 255)));
      else
        emit_pixels(1);
    end
    wait_drained();
    emit_pixels(12);
  endtask

  // Run to the frame end and on into the next frame
  task automatic test_frame_wrap();
    sweep_to(FrameRows - EdgeRows);
    set_border(4'd15);
    sweep_to(0);
    emit_pixels(20);
    set_border(4'd0);
    emit_pixels(10);
  endtask

  // Output ready: long holds on request, otherwise a changing stall pattern
  always @(negedge clk_i) begin
    if (hold_asks != hold_taken) begin
      hold_taken++;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(64, 256);
        rx_period = $urandom_range(2, 5);
      end
      rx_mode_left--;
      case (rx_mode)
        RxAlways: rx_want = 1'b1;
        RxMostly: rx_want = ($urandom_range(0, 3) != 0);
        RxHalf:   rx_want = ($urandom_range(0, 1) != 0);
        default: begin
          rx_want = (rx_phase != 0);
          rx_phase = (rx_phase + 1) % rx_period;
        end
      endcase
      if (!rx_want && stall_run < StallMax) begin
        stall_run++;
        rsp_if.ready <= 1'b0;
      end else begin
        stall_run = 0;
        rsp_if.ready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  // Compare every accepted pixel with the oldest prediction
  always @(posedge clk_i) begin : check_pixels
    pixel_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_pixels.size() == 0) begin
        $error("pixel arrived with no prediction pending");
        error_count++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("red", want.red, rsp_if.red);
        check_field("green", want.green, rsp_if.green);
        check_field("blue", want.blue, rsp_if.blue);
        check_field("line_end", 8'(want.line_end), 8'(rsp_if.line_end));
        check_field("frame_end", 8'(want.frame_end), 8'(rsp_if.frame_end));
      end
    end
  end

  initial begin : run
    int waited;
    req_if.valid = 1'b0;
    req_if.command = CmdWrite;
    req_if.address = '0;
    req_if.data = '0;
    rsp_if.ready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    foreach (video_copy[i]) video_copy[i] = '0;
    rst_ni = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_border();
    test_store_extremes();
    test_top_border();
    test_active_random();
    test_backpressure();
    test_frame_wrap();

    // Drain with a bound, then allow the pipeline to settle
    req_if.valid <= 1'b0;
    for (waited = 0; expected_pixels.size() != 0 && waited < DrainLimit; waited++)
      @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (expected_pixels.size() != 0) begin
      $error("%0d predicted pixels never arrived", expected_pixels.size());
      error_count++;
    end
    if (error_count == 0)
      $display("bitmap_attribute_raster_scan_test passed");
    else
      $display("bitmap_attribute_raster_scan_test failed");
    $finish;
  end

endmodule

// File: bitmap_attribute_raster_scan.f
design/bars_pkg.sv
design/bars_if.sv
design/bars_store.sv
design/bitmap_attribute_raster_scan.sv
tb/sv/bitmap_attribute_raster_scan_test.sv
